// File: src/wmf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wmf_pkg
// Shared constants, types and register indexes of the window median filter.
// ---------------------------------------------------------------------------
package wmf_pkg;

   localparam int WINDOW      = 5;
   localparam int MAX_WIDTH   = 1024;
   localparam int HALF        = ((WINDOW - 3) / 2) + 1;
   localparam int SPAN        = 2 * HALF + 1;
   localparam int AREA        = SPAN * SPAN;
   localparam int RANK        = AREA / 2;
   localparam int ADDR_W      = $clog2(MAX_WIDTH);
   localparam int WID_W       = $clog2(MAX_WIDTH + 1);
   localparam int DIM_W       = 11;
   localparam int ROW_W       = 12;
   localparam int RANK_W      = $clog2(AREA);
   localparam int J_W         = $clog2(HALF + 1);
   localparam int PIPE_STAGES = 5;
   localparam int FIFO_DEPTH  = 2 ** $clog2(2 * (PIPE_STAGES + 2 * HALF + 1));
   localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
   localparam int CSR_INDEX_W = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 8'd1;
   localparam logic [DIM_W-1:0]       RESET_WIDTH      = 11'd320;
   localparam logic [DIM_W-1:0]       RESET_HEIGHT     = 11'd240;

   typedef logic [7:0]                  pixel_type;
   typedef logic [SPAN-1:0][7:0]        col_type;
   typedef logic [SPAN-2:0][7:0]        store_type;
   typedef logic [AREA-1:0][7:0]        win_type;

   typedef struct packed {
      logic valid;
      logic emit;
      logic last;
      logic fend;
   } meta_type;

   typedef struct packed {
      pixel_type median;
      logic      run_last;
      logic      frame_end;
   } result_type;

endpackage

`default_nettype wire

// File: src/wmf_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wmf_if
// Word channels of the window median filter: pixels in, medians out, CSR.
// ---------------------------------------------------------------------------
interface wmf_req_if import wmf_pkg::*;;
   logic      valid;
   logic      ready;
   logic      command;
   pixel_type pixel;
   modport source (output valid, command, pixel, input ready);
   modport sink   (input valid, command, pixel, output ready);
endinterface

interface wmf_rsp_if import wmf_pkg::*;;
   logic      valid;
   logic      ready;
   pixel_type median;
   logic      run_last;
   logic      frame_end;
   modport source (output valid, median, run_last, frame_end, input ready);
   modport sink   (input valid, median, run_last, frame_end, output ready);
endinterface

interface wmf_csr_if import wmf_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [DIM_W-1:0]       data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: src/wmf_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wmf_cell
// One window column; shifts to its neighbor, clears at row start.
// ---------------------------------------------------------------------------
module wmf_cell import wmf_pkg::*; (
   input  wire logic    clock,
   input  wire logic    shift,
   input  wire logic    clear,
   input  wire col_type col_prev,
   output col_type      col_out
);

   col_type col_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         col_ff <= clear ? '0 : col_prev;
      end
   end

   assign col_out = col_ff;

endmodule

`default_nettype wire

// File: src/wmf_median.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wmf_median
// Rank-select median: compare matrix, rank count, pick, three stages.
// ---------------------------------------------------------------------------
module wmf_median import wmf_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire meta_type in_meta,
   input  wire win_type  in_win,
   output meta_type      out_meta,
   output pixel_type     out_median
);

   meta_type                       m1_meta_ff, m2_meta_ff, m3_meta_ff;
   win_type                        m1_win_ff, m2_win_ff;
   logic [AREA-1:0][AREA-1:0]      lt_in, m1_lt_ff;
   logic [AREA-1:0][RANK_W-1:0]    rank_in, m2_rank_ff;
   pixel_type                      median_in, median_ff;

   always_comb begin
      for (int i = 0; i < AREA; i++) begin
         for (int j = 0; j < AREA; j++) begin
            lt_in[i][j] = (j != i) && ((in_win[j] < in_win[i]) ||
                          ((in_win[j] == in_win[i]) && (j < i)));
         end
      end
   end

   always_comb begin
      for (int i = 0; i < AREA; i++) begin
         rank_in[i] = RANK_W'($countones(m1_lt_ff[i]));
      end
   end

   always_comb begin
      median_in = '0;
      for (int i = 0; i < AREA; i++) begin
         if (m2_rank_ff[i] == RANK_W'(RANK)) begin
            median_in = median_in | m2_win_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_meta_ff <= '0;
         m2_meta_ff <= '0;
         m3_meta_ff <= '0;
      end else begin
         m1_meta_ff <= in_meta;
         m2_meta_ff <= m1_meta_ff;
         m3_meta_ff <= m2_meta_ff;
      end
      m1_win_ff  <= in_win;
      m1_lt_ff   <= lt_in;
      m2_win_ff  <= m1_win_ff;
      m2_rank_ff <= rank_in;
      median_ff  <= median_in;
   end

   assign out_meta   = m3_meta_ff;
   assign out_median = median_ff;

endmodule

`default_nettype wire

// File: src/window_median_filter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// window_median_filter_core
// Streaming 2-D median filter over a square window with zero padding.
// ---------------------------------------------------------------------------
// Pipeline: input register s1, column cells and s2, median stages m1, m2, m3, then the result queue.
// Throughput: one pixel per cycle while the result queue has room; a row-end word
// holds ready low while the right-edge windows are shifted out of the column cells.
// Reset: synchronous; counters and queue clear at once, CSRs load 320 x 240, line store is
// left unwritten and rows not yet written in the frame are masked to zero.
module window_median_filter_core import wmf_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   wmf_req_if.sink   req,
   wmf_rsp_if.source rsp,
   wmf_csr_if.sink   csr
);

   logic [DIM_W-1:0]   width_ff, height_ff;
   logic [WID_W-1:0]   w_eff;
   logic [DIM_W-1:0]   h_eff;
   logic [ADDR_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic               req_fire, csr_fire, row_end, row_valid, bottom_row;
   logic               csr_restart;
   pixel_type          pix_store;

   logic [J_W-1:0]     inj_j_ff, inj_j_in;
   logic [ADDR_W-1:0]  inj_col_ff;
   logic               inj_rv_ff, inj_bottom_ff;

   meta_type           s1_meta_ff, s1_meta_in, s2_meta_ff;
   logic               s1_item_ff, s1_first_ff;
   logic [ADDR_W-1:0]  s1_col_ff;
   logic [ROW_W-1:0]   s1_row_ff;
   pixel_type          s1_pix_ff;

   store_type          mem [MAX_WIDTH];
   store_type          mem_q_ff, wr_word;
   col_type            col_new;
   col_type            cols [SPAN];
   win_type            win;

   meta_type           med_meta;
   pixel_type          med_value;

   result_type         fifo [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_AW:0]   fifo_count_ff;
   logic               push, pop;

   // frame geometry
   always_comb begin
      if (width_ff == '0) begin
         w_eff = WID_W'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         w_eff = WID_W'(MAX_WIDTH);
      end else begin
         w_eff = WID_W'(width_ff);
      end
      h_eff = (height_ff == '0) ? DIM_W'(1) : height_ff;
   end

   assign csr.ready   = 1'b1;
   assign csr_fire    = csr.valid && csr.ready;
   assign csr_restart = csr_fire &&
                        ((csr.index == CSR_FRAME_WIDTH) || (csr.index == CSR_FRAME_HEIGHT));
   assign req.ready = (inj_j_ff == '0) &&
                      (int'(fifo_count_ff) + PIPE_STAGES + HALF + 1 <= FIFO_DEPTH);
   assign req_fire  = req.valid && req.ready;

   assign row_end    = (int'(col_ff) == int'(w_eff) - 1);
   assign row_valid  = (int'(row_ff) >= HALF) && (int'(row_ff) - HALF < int'(h_eff));
   assign bottom_row = (int'(row_ff) - HALF == int'(h_eff) - 1);
   assign pix_store  = ((int'(row_ff) < int'(h_eff)) && !req.command) ? req.pixel : '0;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_restart) begin
         col_in = '0;
         row_in = '0;
      end else if (req_fire) begin
         if (row_end) begin
            col_in = '0;
            row_in = (int'(row_ff) == int'(h_eff) + HALF - 1) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_comb begin
      inj_j_in = inj_j_ff;
      if (csr_restart) begin
         inj_j_in = '0;
      end else if (req_fire && row_end) begin
         inj_j_in = J_W'(1);
      end else if (inj_j_ff != '0) begin
         inj_j_in = (int'(inj_j_ff) == HALF) ? '0 : inj_j_ff + 1'b1;
      end
   end

   always_comb begin
      s1_meta_in = '0;
      if (req_fire) begin
         s1_meta_in.valid = 1'b1;
         s1_meta_in.emit  = row_valid && (int'(col_ff) >= HALF);
         s1_meta_in.last  = !row_end;
      end else if (inj_j_ff != '0) begin
         s1_meta_in.valid = 1'b1;
         s1_meta_in.emit  = inj_rv_ff && (int'(inj_col_ff) + int'(inj_j_ff) >= HALF);
         s1_meta_in.last  = (int'(inj_j_ff) == HALF);
         s1_meta_in.fend  = (int'(inj_j_ff) == HALF) && inj_bottom_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= RESET_WIDTH;
         height_ff     <= RESET_HEIGHT;
         col_ff        <= '0;
         row_ff        <= '0;
         inj_j_ff      <= '0;
         s1_meta_ff    <= '0;
         s2_meta_ff    <= '0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         inj_j_ff   <= inj_j_in;
         s1_meta_ff <= s1_meta_in;
         s2_meta_ff <= s1_meta_ff;
         if (csr_fire) begin
            case (csr.index)
               CSR_FRAME_WIDTH: begin
                  width_ff <= csr.data;
               end
               CSR_FRAME_HEIGHT: begin
                  height_ff <= csr.data;
               end
               default: begin
               end
            endcase
         end
      end
      if (req_fire) begin
         inj_col_ff    <= col_ff;
         inj_rv_ff     <= row_valid;
         inj_bottom_ff <= bottom_row;
         s1_col_ff     <= col_ff;
         s1_row_ff     <= row_ff;
         s1_pix_ff     <= pix_store;
         s1_first_ff   <= (col_ff == '0);
      end
      s1_item_ff <= req_fire;
   end

   // line store: older rows of one column packed in one word
   always_comb begin
      col_new = '0;
      if (s1_item_ff) begin
         col_new[0] = s1_pix_ff;
         for (int k = 1; k < SPAN; k++) begin
            col_new[k] = (int'(s1_row_ff) >= k) ? mem_q_ff[k-1] : '0;
         end
      end
      for (int k = 0; k < SPAN - 1; k++) begin
         wr_word[k] = col_new[k];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         mem_q_ff <= mem[col_ff];
      end
      if (s1_meta_ff.valid && s1_item_ff) begin
         mem[s1_col_ff] <= wr_word;
      end
   end

   // column cells, newest column in cell 0
   for (genvar k = 0; k < SPAN; k++) begin : g_cell
      wmf_cell u_cell (
         .clock    (clock),
         .shift    (s1_meta_ff.valid),
         .clear    ((k != 0) && s1_item_ff && s1_first_ff),
         .col_prev ((k == 0) ? col_new : cols[(k == 0) ? 0 : k - 1]),
         .col_out  (cols[k])
      );
      for (genvar i = 0; i < SPAN; i++) begin : g_tap
         assign win[k * SPAN + i] = cols[k][i];
      end
   end

   wmf_median u_median (
      .clock      (clock),
      .reset      (reset),
      .in_meta    (s2_meta_ff),
      .in_win     (win),
      .out_meta   (med_meta),
      .out_median (med_value)
   );

   // result queue
   assign push = med_meta.valid && med_meta.emit;
   assign pop  = rsp.valid && rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         fifo_count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         fifo_count_ff <= fifo_count_ff + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
      end
      if (push) begin
         fifo[wr_ptr_ff] <= '{median: med_value, run_last: med_meta.last,
                              frame_end: med_meta.fend};
      end
   end

   assign rsp.valid     = (fifo_count_ff != '0);
   assign rsp.median    = fifo[rd_ptr_ff].median;
   assign rsp.run_last  = fifo[rd_ptr_ff].run_last;
   assign rsp.frame_end = fifo[rd_ptr_ff].frame_end;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && (int'(fifo_count_ff) == FIFO_DEPTH)))
      else $error("result queue overflow");

   a_inject_stall: assert property (@(posedge clock) disable iff (reset)
      (inj_j_ff != '0) |-> !req.ready)
      else $error("word accepted during edge shift-out");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.frame_end) |-> rsp.run_last)
      else $error("frame end not on last word of run");

   a_row_end_inject: assert property (@(posedge clock) disable iff (reset)
      (req_fire && row_end && !csr_fire) |=> (inj_j_ff == J_W'(1)))
      else $error("row end did not start shift-out");

endmodule

`default_nettype wire

// File: tb/tb_wmf_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_wmf_if
// Testbench-side note: channel interfaces come from the RTL interface file.
// ---------------------------------------------------------------------------
package tb_wmf_types;
   import wmf_pkg::*;
   typedef struct packed {
      pixel_type median;
      logic      run_last;
      logic      frame_end;
   } median_word_type;
endpackage

// File: tb/tb_window_median_filter_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_window_median_filter_core
// Streams pixel frames of several sizes through the median filter, predicts
// each window median in a local model and checks every output word in order.
// ---------------------------------------------------------------------------
module tb_window_median_filter_core;
   import wmf_pkg::*;
   import tb_wmf_types::*;

   logic clock = 0;
   logic reset = 1;
   always #5 clock = ~clock;

   wmf_req_if req ();
   wmf_rsp_if rsp ();
   wmf_csr_if csr ();

   window_median_filter_core uut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   pixel_type       rows_mem [SPAN][MAX_WIDTH];
   int              col_pos, row_pos;
   logic [DIM_W-1:0] width_reg, height_reg;
   median_word_type medians_due [$];
   int              fails;
   int              cycles;
   int              quiet_left;

   function automatic int act_width();
      int w;
      w = int'(width_reg);
      if (w < 1) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
   endfunction

   function automatic int act_height();
      return (height_reg < 1) ? 1 : int'(height_reg);
   endfunction

   function automatic pixel_type window_rank(int r, int c, int w);
      int hist [256];
      int seen, rr, cc, px;
      for (int v = 0; v < 256; v++) hist[v] = 0;
      for (int dr = -HALF; dr <= HALF; dr++)
         for (int dc = -HALF; dc <= HALF; dc++) begin
            rr = r + dr;
            cc = c + dc;
            px = 0;
            if (rr >= 0 && cc >= 0 && cc < w) px = rows_mem[rr % SPAN][cc];
            hist[px]++;
         end
      seen = 0;
      for (int v = 0; v < 256; v++) begin
         seen += hist[v];
         if (seen > RANK) return pixel_type'(v);
      end
      return 8'd255;
   endfunction

   function automatic void predict_pixel(logic cmd, pixel_type px);
      int w, h, lo, hi, r;
      median_word_type m;
      w = act_width();
      h = act_height();
      if (col_pos >= w) col_pos = 0;
      if (row_pos >= h + HALF) row_pos = 0;
      rows_mem[row_pos % SPAN][col_pos] = (row_pos < h && !cmd) ? px : 8'd0;
      r = row_pos - HALF;
      if (r >= 0 && r < h) begin
         lo = col_pos - HALF;
         hi = lo;
         if (col_pos == w - 1) begin
            if (lo < 0) lo = 0;
            hi = col_pos;
         end
         if (lo >= 0)
            for (int c = lo; c <= hi; c++) begin
               m.median    = window_rank(r, c, w);
               m.run_last  = (c == hi);
               m.frame_end = (r == h - 1 && c == w - 1);
               medians_due = {medians_due, m};
            end
      end
      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= h + HALF) row_pos = 0;
      end
   endfunction

   // idle ~8%, none during quiet stretch
   function automatic bit take_gap();
      return quiet_left == 0 && $urandom_range(99) < 8;
   endfunction

   initial begin
      req.valid = 0; req.command = 0; req.pixel = 0;
      csr.valid = 0; csr.index = CSR_FRAME_WIDTH; csr.data = 0;
      rsp.ready = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (quiet_left > 0) quiet_left <= quiet_left - 1;
      if (!reset) rsp.ready <= !take_gap();
      if (cycles > 400000) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) begin
      median_word_type exp_w;
      if (!reset && rsp.valid && rsp.ready) begin
         if (medians_due.size() == 0) begin
            $error("unexpected word median=%0d", rsp.median);
            fails++;
         end else begin
            exp_w = medians_due.pop_front();
            if (rsp.median !== exp_w.median) begin
               $error("median exp %0d got %0d", exp_w.median, rsp.median); fails++;
            end
            if (rsp.run_last !== exp_w.run_last) begin
               $error("run_last exp %0d got %0d", exp_w.run_last, rsp.run_last); fails++;
            end
            if (rsp.frame_end !== exp_w.frame_end) begin
               $error("frame_end exp %0d got %0d", exp_w.frame_end, rsp.frame_end);
               fails++;
            end
         end
      end
   end

   task automatic send_pixel(logic cmd, pixel_type px);
      if (take_gap()) begin
         req.valid <= 0;
         do @(posedge clock); while (take_gap());
      end
      req.valid   <= 1;
      req.command <= cmd;
      req.pixel   <= px;
      do @(posedge clock); while (!req.ready);
      predict_pixel(cmd, px);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req.valid <= 0;
      while (medians_due.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [DIM_W-1:0] val);
      drain();
      csr.valid <= 1;
      csr.index <= idx;
      csr.data  <= val;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 0;
      if (idx == CSR_FRAME_WIDTH) width_reg = val;
      else if (idx == CSR_FRAME_HEIGHT) height_reg = val;
      col_pos = 0;
      row_pos = 0;
   endtask

   task automatic run_frame(int kind);
      int n;
      n = act_width() * (act_height() + HALF);
      for (int i = 0; i < n; i++) begin
         logic cmd;
         pixel_type px;
         cmd = (row_pos >= act_height());
         if ($urandom_range(19) == 0) cmd = ~cmd;
         case (kind)
            0: px = (i % 2) ? 8'hFF : 8'h00;
            default: px = pixel_type'($urandom);
         endcase
         send_pixel(cmd, px);
      end
   endtask

   task automatic test_directed();
      write_reg(CSR_FRAME_WIDTH, 11'd3);
      write_reg(CSR_FRAME_HEIGHT, 11'd3);
      run_frame(0);
   endtask

   task automatic test_small_sizes();
      write_reg(CSR_FRAME_WIDTH, 11'd0);
      write_reg(CSR_FRAME_HEIGHT, 11'd0);
      run_frame(1);
      write_reg(CSR_FRAME_WIDTH, 11'd2);
      write_reg(CSR_FRAME_HEIGHT, 11'd4);
      run_frame(1);
   endtask

   task automatic test_random_frames();
      write_reg(CSR_FRAME_WIDTH, 11'd7);
      write_reg(CSR_FRAME_HEIGHT, 11'd5);
      quiet_left = 60;
      run_frame(1);
      run_frame(1);
      write_reg(CSR_FRAME_WIDTH, 11'd12);
      write_reg(CSR_FRAME_HEIGHT, 11'd6);
      run_frame(1);
      write_reg(CSR_FRAME_WIDTH, 11'd10);
      write_reg(CSR_FRAME_HEIGHT, 11'd10);
      run_frame(1);
   endtask

   task automatic test_wide_rows();
      write_reg(CSR_FRAME_WIDTH, 11'd2047);
      write_reg(CSR_FRAME_HEIGHT, 11'd1);
      for (int i = 0; i < 60; i++) send_pixel(1'b0, pixel_type'($urandom));
      write_reg(CSR_FRAME_HEIGHT, 11'd2047);
      for (int i = 0; i < 30; i++)
         send_pixel(1'($urandom_range(1)), pixel_type'($urandom));
   endtask

   initial begin
      fails = 0; cycles = 0; quiet_left = 0;
      col_pos = 0; row_pos = 0;
      width_reg = RESET_WIDTH; height_reg = RESET_HEIGHT;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_small_sizes();
      test_random_frames();
      test_wide_rows();
      drain();
      if (fails == 0 && medians_due.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule

// File: files.f
src/wmf_pkg.sv
src/wmf_if.sv
src/wmf_cell.sv
src/wmf_median.sv
src/window_median_filter_core.sv
tb/tb_wmf_if.sv
tb/tb_window_median_filter_core.sv
